// ===== rtl/twofish_h_function_macros.svh =====
// Assertion macros shared by the Twofish h function RTL
`ifndef TWOFISH_H_FUNCTION_MACROS_SVH
`define TWOFISH_H_FUNCTION_MACROS_SVH

// same-cycle implication
`define TFH_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tfh assertion failed");

// next-cycle implication
`define TFH_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tfh assertion failed");

`endif

// ===== rtl/tfh_pkg.sv =====
// Types, constants and permutation/GF functions for the Twofish h function
package tfh_pkg;

   localparam int WORD_W    = 32;
   localparam int KLEN_W    = 3;
   localparam int CSR_IDX_W = 3;
   localparam int LANES     = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LEN   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_WORD0 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_WORD1 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_WORD2 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_WORD3 = 3'd4;

   localparam logic [KLEN_W-1:0] KEY_LEN_2 = 3'd2;
   localparam logic [KLEN_W-1:0] KEY_LEN_3 = 3'd3;
   localparam logic [KLEN_W-1:0] KEY_LEN_4 = 3'd4;

   // q0/q1 select per byte lane (bit i = lane i, 1 = q1)
   localparam logic [LANES-1:0] QSEL_K4  = 4'b1001;
   localparam logic [LANES-1:0] QSEL_K3  = 4'b0011;
   localparam logic [LANES-1:0] QSEL_K2A = 4'b1010;
   localparam logic [LANES-1:0] QSEL_K2B = 4'b1100;
   localparam logic [LANES-1:0] QSEL_FIN = 4'b0101;

   localparam logic [7:0] GF_POLY_LO = 8'h69;

   localparam logic [3:0] ROT_NIB [16] = '{
      4'd0, 4'd8, 4'd1, 4'd9, 4'd2, 4'd10, 4'd3, 4'd11,
      4'd4, 4'd12, 4'd5, 4'd13, 4'd6, 4'd14, 4'd7, 4'd15};
   localparam logic [3:0] MIX_NIB [16] = '{
      4'd0, 4'd9, 4'd2, 4'd11, 4'd4, 4'd13, 4'd6, 4'd15,
      4'd8, 4'd1, 4'd10, 4'd3, 4'd12, 4'd5, 4'd14, 4'd7};

   localparam logic [3:0] Q_T [2][4][16] = '{
      '{
         '{4'd8, 4'd1, 4'd7, 4'd13, 4'd6, 4'd15, 4'd3, 4'd2,
           4'd0, 4'd11, 4'd5, 4'd9, 4'd14, 4'd12, 4'd10, 4'd4},
         '{4'd14, 4'd12, 4'd11, 4'd8, 4'd1, 4'd2, 4'd3, 4'd5,
           4'd15, 4'd4, 4'd10, 4'd6, 4'd7, 4'd0, 4'd9, 4'd13},
         '{4'd11, 4'd10, 4'd5, 4'd14, 4'd6, 4'd13, 4'd9, 4'd0,
           4'd12, 4'd8, 4'd15, 4'd3, 4'd2, 4'd4, 4'd7, 4'd1},
         '{4'd13, 4'd7, 4'd15, 4'd4, 4'd1, 4'd2, 4'd6, 4'd14,
           4'd9, 4'd11, 4'd3, 4'd0, 4'd8, 4'd5, 4'd12, 4'd10}
      },
      '{
         '{4'd2, 4'd8, 4'd11, 4'd13, 4'd15, 4'd7, 4'd6, 4'd14,
           4'd3, 4'd1, 4'd9, 4'd4, 4'd0, 4'd10, 4'd12, 4'd5},
         '{4'd1, 4'd14, 4'd2, 4'd11, 4'd4, 4'd12, 4'd3, 4'd7,
           4'd6, 4'd13, 4'd10, 4'd5, 4'd15, 4'd9, 4'd0, 4'd8},
         '{4'd4, 4'd12, 4'd7, 4'd5, 4'd1, 4'd6, 4'd9, 4'd10,
           4'd0, 4'd14, 4'd13, 4'd8, 4'd2, 4'd11, 4'd3, 4'd15},
         '{4'd11, 4'd9, 4'd5, 4'd1, 4'd12, 4'd3, 4'd13, 4'd14,
           4'd6, 4'd4, 4'd7, 4'd15, 4'd2, 4'd0, 4'd8, 4'd10}
      }
   };

   // MDS coefficients, [output byte][input byte]
   localparam logic [7:0] MDS_M [LANES][LANES] = '{
      '{8'h01, 8'hEF, 8'h5B, 8'h5B},
      '{8'h5B, 8'hEF, 8'hEF, 8'h01},
      '{8'hEF, 8'h5B, 8'h01, 8'hEF},
      '{8'hEF, 8'h01, 8'hEF, 8'h5B}
   };

   typedef struct packed {
      logic [KLEN_W-1:0]            key_len;
      logic [LANES-1:0][WORD_W-1:0] key_word;
   } tfh_key_type;

   function automatic logic [7:0] perm_q(input logic sel, input logic [7:0] x);
      logic [3:0] hi, lo, h1, l1, h2, l2, h3, l3, h4, l4;
      hi = x[7:4];
      lo = x[3:0];
      h1 = hi ^ lo;
      l1 = ROT_NIB[lo] ^ MIX_NIB[hi];
      h2 = Q_T[sel][0][h1];
      l2 = Q_T[sel][1][l1];
      h3 = h2 ^ l2;
      l3 = ROT_NIB[l2] ^ MIX_NIB[h2];
      h4 = Q_T[sel][2][h3];
      l4 = Q_T[sel][3][l3];
      return {l4, h4};
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc, sh;
      acc = '0;
      sh  = a;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) acc = acc ^ sh;
         sh = {sh[6:0], 1'b0} ^ (sh[7] ? GF_POLY_LO : 8'h00);
      end
      return acc;
   endfunction

endpackage

// ===== rtl/tfh_if.sv =====
// Valid/ready channel interfaces for the h function input and result
interface tfh_req_if;
   import tfh_pkg::*;
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] word_in;
   modport source (output valid, output word_in, input ready);
   modport sink   (input valid, input word_in, output ready);
endinterface

interface tfh_rsp_if;
   import tfh_pkg::*;
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] word_out;
   modport source (output valid, output word_out, input ready);
   modport sink   (input valid, input word_out, output ready);
endinterface

// ===== rtl/tfh_core.sv =====
// Keyed q layers and MDS product of the Twofish h function
module tfh_core (
   input  tfh_pkg::tfh_key_type         key,
   input  logic [tfh_pkg::WORD_W-1:0]   word_in,
   output logic [tfh_pkg::WORD_W-1:0]   word_out
);
   import tfh_pkg::*;

   logic use_k4, use_k3, use_k2;
   logic [LANES-1:0][7:0] b4, b3, b2, y;

   assign use_k4 = (key.key_len == KEY_LEN_4);
   assign use_k3 = (key.key_len == KEY_LEN_3) || (key.key_len == KEY_LEN_4);
   assign use_k2 = (key.key_len == KEY_LEN_2) || use_k3;

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         b4[i] = use_k4 ? perm_q(QSEL_K4[i], word_in[8*i +: 8]) ^ key.key_word[3][8*i +: 8]
                        : word_in[8*i +: 8];
         b3[i] = use_k3 ? perm_q(QSEL_K3[i], b4[i]) ^ key.key_word[2][8*i +: 8] : b4[i];
         b2[i] = use_k2 ? perm_q(QSEL_K2B[i],
                                 perm_q(QSEL_K2A[i], b3[i]) ^ key.key_word[1][8*i +: 8])
                          ^ key.key_word[0][8*i +: 8]
                        : b3[i];
         y[i]  = perm_q(QSEL_FIN[i], b2[i]);
      end
   end

   always_comb begin
      for (int j = 0; j < LANES; j++) begin
         word_out[8*j +: 8] = gf_mul(y[0], MDS_M[j][0]) ^ gf_mul(y[1], MDS_M[j][1])
                            ^ gf_mul(y[2], MDS_M[j][2]) ^ gf_mul(y[3], MDS_M[j][3]);
      end
   end

endmodule

// ===== rtl/twofish_h_function.sv =====
// Twofish h function top level: key registers, input and result registers
//
// Usage:
//   req_ch  - valid/ready input channel, one 32-bit word_in per transfer.
//   rsp_ch  - valid/ready result channel, one 32-bit word_out per transfer.
//   csr_*   - write-only key registers: index 0 key_len, 1..4 key_word0..3.
//             Write them only while no word is in flight.
// Path: an accepted word goes through the input register, the h function
//   logic and then the result register.
// Throughput: one word per cycle while rsp_ch.ready is high; the longest
//   path is five q layers of nibble table lookups and the core's MDS multiply.
// Reset: synchronous, active high; empties both pipeline registers and
//   sets key_len to 2 and all key words to zero.
// Stall: when rsp_ch.ready is low the result register holds, the input
//   register fills behind it, and req_ch.ready drops only when both are
//   full. No transfer is dropped or repeated.
module twofish_h_function (
   input  logic                            clock,
   input  logic                            reset,
   tfh_req_if.sink                         req_ch,
   tfh_rsp_if.source                       rsp_ch,
   input  logic                            csr_we,
   input  logic [tfh_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tfh_pkg::WORD_W-1:0]      csr_wdata
);
   import tfh_pkg::*;

   tfh_key_type       key_ff, key_in;
   logic              s1_valid_ff, s1_valid_in;
   logic [WORD_W-1:0] s1_word_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_word_ff;
   logic [WORD_W-1:0] h_word;
   logic              s2_load, s1_load;

   assign s2_load      = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !s1_valid_ff || s2_load;
   assign s1_load      = req_ch.valid && req_ch.ready;

   assign s1_valid_in  = s1_load || (s1_valid_ff && !s2_load);
   assign rsp_valid_in = s2_load ? s1_valid_ff : rsp_valid_ff;

   always_comb begin
      key_in = key_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_KEY_LEN:   key_in.key_len     = csr_wdata[KLEN_W-1:0];
            CSR_KEY_WORD0: key_in.key_word[0] = csr_wdata;
            CSR_KEY_WORD1: key_in.key_word[1] = csr_wdata;
            CSR_KEY_WORD2: key_in.key_word[2] = csr_wdata;
            CSR_KEY_WORD3: key_in.key_word[3] = csr_wdata;
            default:       key_in = key_ff;
         endcase
      end
   end

   tfh_core u_core (
      .key      (key_ff),
      .word_in  (s1_word_ff),
      .word_out (h_word)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff.key_len  <= KEY_LEN_2;
         key_ff.key_word <= '0;
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         key_ff       <= key_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) s1_word_ff <= req_ch.word_in;
      if (s2_load) rsp_word_ff <= h_word;
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.word_out = rsp_word_ff;

`include "twofish_h_function_macros.svh"

   `TFH_ASSERT_IMP(a_ready_low_full, clock, reset, !req_ch.ready, s1_valid_ff && rsp_valid_ff)
   `TFH_ASSERT_NXT(a_advance_fills, clock, reset, s1_valid_ff && s2_load, rsp_valid_ff)
   `TFH_ASSERT_NXT(a_s1_holds, clock, reset, s1_valid_ff && !s2_load,
                   s1_valid_ff && $stable(s1_word_ff))
   `TFH_ASSERT_NXT(a_key_len_write, clock, reset, csr_we && (csr_index == CSR_KEY_LEN),
                   key_ff.key_len == $past(csr_wdata[KLEN_W-1:0]))

endmodule
